@@ rtl/drum_pkg.sv @@
// Shared constants for the DRUM approximate multiplier.
// No dependencies; used by drum_approximate_multiply.
`timescale 1ns / 1ps

package drum_pkg;

  // Width of the signed product field on the result stream.
  localparam int unsigned PRODUCT_WIDTH = 32;

  // Result stream data width, rounded up to whole bytes.
  localparam int unsigned OUT_TDATA_WIDTH = ((PRODUCT_WIDTH + 7) / 8) * 8;

endpackage

@@ rtl/drum_approximate_multiply.sv @@
// Top level of the DRUM approximate signed multiplier.
// Depends on drum_pkg (product width constants).
`timescale 1ns / 1ps

// DRUM approximate multiplier: one operand pair per request on the input stream, one
// signed product per request on the result stream. Each operand's magnitude keeps its
// leading KEEP_BITS bits starting at the leading one; below that window the bits are
// dropped and the lowest kept bit is forced to one so the truncation error is unbiased.
// Magnitudes of up to KEEP_BITS bits pass exactly. Reduced magnitudes are multiplied
// and the sign is restored from the XOR of the operand signs; a zero operand gives zero.
// Rate: one request per clock while out_tready is high. An accepted operand pair is held
// in the operand register; the leading-one search, reduction and one OPERAND_WIDTH x
// OPERAND_WIDTH multiplier then feed the product register, which presents the product.
// in_tready follows out_tready combinationally, so a held result does not block a new
// request while the operand register is free.
module drum_approximate_multiply #(
  parameter int unsigned OPERAND_WIDTH = 16,
  parameter int unsigned KEEP_BITS     = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [OPERAND_WIDTH-1:0] operand_x, [2*OPERAND_WIDTH-1:OPERAND_WIDTH] operand_y,
  // zero padding up to a whole byte
  input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] in_tdata,
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] product
  output logic [drum_pkg::OUT_TDATA_WIDTH-1:0] out_tdata
);

  localparam int unsigned W        = OPERAND_WIDTH;
  localparam int unsigned MULT_W   = 2 * OPERAND_WIDTH;
  localparam int unsigned PW       = drum_pkg::PRODUCT_WIDTH;
  // Sign handling happens at the wider of the raw product and the output field.
  localparam int unsigned EXT_W    = (MULT_W > PW) ? MULT_W : PW;

  // Keep the leading KEEP_BITS bits from the leading one; force the lowest kept bit.
  function automatic logic [W-1:0] reduce_mag(input logic [W-1:0] mag);
    int          lead;
    int          lo;
    logic [W-1:0] r;
    lead = 0;
    for (int i = 0; i < W; i++) begin
      if (mag[i]) begin
        lead = i;
      end
    end
    r = mag;
    if (lead >= int'(KEEP_BITS)) begin
      lo = lead - int'(KEEP_BITS) + 1;
      for (int i = 0; i < W; i++) begin
        r[i] = (i > lo) ? mag[i] : (i == lo);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: operand register feeds the product register.
  // ---------------------------------------------------------------------------
  logic          opnd_valid_r, opnd_valid_nxt;
  logic          out_valid_r,  out_valid_nxt;
  logic          prod_advance;            // product register can take a new value
  logic [W-1:0]  opnd_x_r, opnd_y_r;
  logic [PW-1:0] product_r, product_nxt;

  assign prod_advance = !out_valid_r || out_tready;
  assign in_tready    = !opnd_valid_r || prod_advance;

  always_comb begin
    opnd_valid_nxt = opnd_valid_r;
    if (in_tready) begin
      opnd_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (prod_advance) begin
      out_valid_nxt = opnd_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath between the operand and product registers.
  // ---------------------------------------------------------------------------
  logic              neg_x, neg_y;
  logic [W-1:0]      mag_x, mag_y;        // most negative operand gives 2^(W-1), exact
  logic [W-1:0]      red_x, red_y;
  logic [MULT_W-1:0] mag_prod;
  logic [EXT_W-1:0]  ext_prod, signed_prod;

  always_comb begin
    neg_x       = opnd_x_r[W-1];
    neg_y       = opnd_y_r[W-1];
    mag_x       = neg_x ? (~opnd_x_r + 1'b1) : opnd_x_r;
    mag_y       = neg_y ? (~opnd_y_r + 1'b1) : opnd_y_r;
    // A zero magnitude stays zero through the reduction, so the product is zero.
    red_x       = reduce_mag(mag_x);
    red_y       = reduce_mag(mag_y);
    mag_prod    = MULT_W'(red_x) * MULT_W'(red_y);
    ext_prod    = EXT_W'(mag_prod);
    signed_prod = (neg_x ^ neg_y) ? (~ext_prod + 1'b1) : ext_prod;
    product_nxt = signed_prod[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opnd_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      opnd_valid_r <= opnd_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      opnd_x_r <= in_tdata[W-1:0];
      opnd_y_r <= in_tdata[2*W-1:W];
    end
    if (prod_advance) begin
      product_r <= product_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drum_pkg::OUT_TDATA_WIDTH'(product_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A pending operand pair moves into the product register when that register frees up.
  assert property (@(posedge clk) disable iff (!rst_n)
    opnd_valid_r && prod_advance |=> out_valid_r)
    else $error("operand pair lost between stages");

  // An empty product register never holds back the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output");

  // A reduced magnitude has at most KEEP_BITS ones.
  assert property (@(posedge clk) disable iff (!rst_n)
    opnd_valid_r |-> ($countones(red_x) <= KEEP_BITS) && ($countones(red_y) <= KEEP_BITS))
    else $error("reduced magnitude wider than the kept window");

  // A zero operand yields a zero product.
  assert property (@(posedge clk) disable iff (!rst_n)
    opnd_valid_r && prod_advance && ((opnd_x_r == '0) || (opnd_y_r == '0))
      |=> (product_r == '0))
    else $error("zero operand gave nonzero product");

endmodule
